@@ sv/jfhs_pkg.sv @@
// ----------------------------------------------------------------------------
// jfhs_pkg: shared types and constants of the frame header scanner
// marker codes, outcome codes, field widths and the result record
// ----------------------------------------------------------------------------
package jfhs_pkg;

  localparam int unsigned LEN_W  = 22;   // image length and byte position
  localparam int unsigned DIM_W  = 16;   // frame width and height
  localparam int unsigned SAMP_W = 4;    // sampling factors
  localparam int unsigned CODE_W = 3;    // outcome code

  localparam logic [LEN_W-1:0] POS_MAX = '1;  // position counter saturates here

  // marker bytes
  localparam logic [7:0] MRK_FILL = 8'hFF;
  localparam logic [7:0] MRK_SOI  = 8'hD8;
  localparam logic [7:0] MRK_EOI  = 8'hD9;
  localparam logic [7:0] MRK_SOS  = 8'hDA;
  localparam logic [7:0] MRK_TEM  = 8'h01;
  localparam logic [7:0] MRK_RST0 = 8'hD0;
  localparam logic [7:0] MRK_RST7 = 8'hD7;
  localparam logic [7:0] MRK_SOF0 = 8'hC0;
  localparam logic [7:0] MRK_SOF2 = 8'hC2;
  localparam logic [7:0] MRK_SOF6 = 8'hC6;
  localparam logic [7:0] MRK_SOFA = 8'hCA;
  localparam logic [7:0] MRK_SOFE = 8'hCE;
  localparam logic [7:0] MRK_DHT  = 8'hC4;
  localparam logic [7:0] MRK_JPG  = 8'hC8;
  localparam logic [7:0] MRK_DAC  = 8'hCC;
  localparam logic [7:0] NIB_MASK = 8'h0F;

  // outcome codes
  localparam logic [CODE_W-1:0] OUT_OK        = 3'd0;
  localparam logic [CODE_W-1:0] OUT_NO_SOI    = 3'd1;
  localparam logic [CODE_W-1:0] OUT_NO_FRAME  = 3'd2;
  localparam logic [CODE_W-1:0] OUT_BAD_COMP  = 3'd3;
  localparam logic [CODE_W-1:0] OUT_ZERO_SIZE = 3'd4;

  localparam int unsigned TDATA_OUT_W = 48;

  typedef struct packed {
    logic              frame_found;
    logic [CODE_W-1:0] outcome;
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic              progressive;
    logic [SAMP_W-1:0] max_h_sampling;
    logic [SAMP_W-1:0] max_v_sampling;
  } result_t;

endpackage

@@ sv/jpeg_frame_header_scanner.sv @@
// ----------------------------------------------------------------------------
// jpeg_frame_header_scanner: finds the frame header of a JPEG byte stream
// checks the start mark, walks the segments and reports the frame geometry
// ----------------------------------------------------------------------------
// usage
//   cfg_wr_en/cfg_wr_data load the file length in bytes while the block is
//   idle; values above MAX_IMAGE_BYTES are clamped to it for bound checks
//   in_* carries one file byte per beat in in_tdata; in_tuser marks the byte
//   at position zero and restarts the parse (the length register is kept)
//   out_* carries at most one result per file, on the byte where the outcome
//   is settled (at the latest the final byte); later bytes are swallowed
//   until the next beat with in_tuser set
// timing
//   one byte per cycle, sustained; every byte is a single compare and counter
//   update in the parser, so in_tready only drops while a result sits in the
//   output register and out_tready is low
//   a result shows on out_tvalid in the cycle after the deciding input beat
// reset
//   rst_n clears the parse state, the length register and the output
//   register; a byte taken without in_tuser after reset counts as position zero
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner #(
  parameter int unsigned MAX_IMAGE_BYTES = 2097152
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [jfhs_pkg::LEN_W-1:0]      cfg_wr_data,   // image_length
  // byte stream in
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,      // [7:0] data_byte
  input  logic                            in_tuser,      // first_byte
  // result out
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] frame_found, [3:1] outcome, [19:4] frame_width, [35:20] frame_height,
  // [36] progressive, [40:37] max_h_sampling, [44:41] max_v_sampling,
  // [47:45] zero
  output logic [jfhs_pkg::TDATA_OUT_W-1:0] out_tdata
);
  import jfhs_pkg::*;

  logic [LEN_W-1:0]       image_length_r;
  logic [LEN_W-1:0]       len_lim;
  logic                   in_beat;
  logic                   res_valid;
  result_t                res;
  logic                   out_valid_r;
  logic [TDATA_OUT_W-1:0] out_data_r;

  // length register; the user writes it only between files, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_length_r <= '0;
    end else if (cfg_wr_en) begin
      image_length_r <= cfg_wr_data;
    end
  end

  // clamp to the largest supported file
  assign len_lim = (32'(image_length_r) > 32'(MAX_IMAGE_BYTES)) ?
                   LEN_W'(MAX_IMAGE_BYTES) : image_length_r;

  // the output register frees its slot in the same cycle it is drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  jfhs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_beat),
    .data_byte  (in_tdata),
    .first_byte (in_tuser),
    .len        (len_lim),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register: loads on a deciding byte, clears when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {3'b000, res.max_v_sampling, res.max_h_sampling, res.progressive,
                     res.frame_height, res.frame_width, res.outcome, res.frame_found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/jfhs_parser.sv @@
// ----------------------------------------------------------------------------
// jfhs_parser: byte-wide marker parser
// holds the parse state and advances it by one byte per accepted beat
// ----------------------------------------------------------------------------
module jfhs_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [7:0]                    data_byte,
  input  logic                          first_byte,
  input  logic [jfhs_pkg::LEN_W-1:0]    len,
  output logic                          res_valid,
  output jfhs_pkg::result_t             res
);
  import jfhs_pkg::*;

  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_SEEK, PH_FILL, PH_LENHI,
    PH_LENLO, PH_SKIP, PH_FRAME, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_c, phase_nxt;
  logic [LEN_W-1:0]   pos_r, pos_c, pos_nxt;
  logic [15:0]        seg_len_r, seg_len_c, seg_len_nxt;
  logic [15:0]        seg_off_r, seg_off_c, seg_off_nxt;
  logic [7:0]         marker_r, marker_c, marker_nxt;
  logic [DIM_W-1:0]   height_r, height_c, height_nxt;
  logic [DIM_W-1:0]   width_r, width_c, width_nxt;
  logic [1:0]         comp_tot_r, comp_tot_c, comp_tot_nxt;
  logic [1:0]         comp_idx_r, comp_idx_c, comp_idx_nxt;
  logic [SAMP_W-1:0]  hmax_r, hmax_c, hmax_nxt;
  logic [SAMP_W-1:0]  vmax_r, vmax_c, vmax_nxt;
  logic               prog_r, prog_c, prog_nxt;

  logic               emit;
  logic [CODE_W-1:0]  code;
  logic [LEN_W:0]     p_x, len_x;
  logic               len_short, p_ge, p1_ge, p2_ge, top_end, seg_over;
  logic [15:0]        sl;
  logic [15:0]        comp_need;
  logic               is_sof, is_prog, is_alone;

  // first byte of a file restarts the parse before the byte is used
  always_comb begin
    if (first_byte) begin
      phase_c = PH_SOI0;   pos_c = '0;      seg_len_c = '0; seg_off_c = '0;
      marker_c = '0;       height_c = '0;   width_c = '0;
      comp_tot_c = '0;     comp_idx_c = '0;
      hmax_c = SAMP_W'(1); vmax_c = SAMP_W'(1); prog_c = 1'b0;
    end else begin
      phase_c = phase_r;   pos_c = pos_r;   seg_len_c = seg_len_r; seg_off_c = seg_off_r;
      marker_c = marker_r; height_c = height_r; width_c = width_r;
      comp_tot_c = comp_tot_r; comp_idx_c = comp_idx_r;
      hmax_c = hmax_r;     vmax_c = vmax_r; prog_c = prog_r;
    end
  end

  // bound compares, one bit wider than the position
  assign p_x       = {1'b0, pos_c};
  assign len_x     = {1'b0, len};
  assign len_short = (len < LEN_W'(4));
  assign p_ge      = (p_x >= len_x);
  assign p1_ge     = ((p_x + (LEN_W+1)'(1)) >= len_x);
  assign p2_ge     = ((p_x + (LEN_W+1)'(2)) >= len_x);
  assign top_end   = ((p_x + (LEN_W+1)'(4)) >= len_x);
  assign sl        = {seg_len_c[15:8], data_byte};
  assign seg_over  = ((p_x - (LEN_W+1)'(1) + (LEN_W+1)'(sl)) > len_x);
  assign comp_need = 16'(8) + 16'({data_byte[1:0], 1'b0}) + 16'(data_byte[1:0]);

  assign is_sof   = (marker_c[7:4] == MRK_SOF0[7:4]) && (marker_c != MRK_DHT)
                    && (marker_c != MRK_JPG) && (marker_c != MRK_DAC);
  assign is_prog  = (marker_c == MRK_SOF2) || (marker_c == MRK_SOF6)
                    || (marker_c == MRK_SOFA) || (marker_c == MRK_SOFE);
  assign is_alone = (data_byte == MRK_TEM)
                    || ((data_byte >= MRK_RST0) && (data_byte <= MRK_RST7));

  always_comb begin
    phase_nxt = phase_c;   pos_nxt = pos_c;   seg_len_nxt = seg_len_c;
    seg_off_nxt = seg_off_c; marker_nxt = marker_c;
    height_nxt = height_c; width_nxt = width_c;
    comp_tot_nxt = comp_tot_c; comp_idx_nxt = comp_idx_c;
    hmax_nxt = hmax_c;     vmax_nxt = vmax_c; prog_nxt = prog_c;
    emit = 1'b0;
    code = OUT_OK;

    if (phase_c != PH_DONE) begin
      if (pos_c != POS_MAX) begin
        pos_nxt = pos_c + LEN_W'(1);
      end
      if (phase_c == PH_SOI0) begin
        if (len_short || data_byte != MRK_FILL) begin
          emit = 1'b1; code = OUT_NO_SOI;
        end else begin
          phase_nxt = PH_SOI1;
        end
      end else if (phase_c == PH_SOI1) begin
        if (len_short || p_ge || data_byte != MRK_SOI) begin
          emit = 1'b1; code = OUT_NO_SOI;
        end else if (top_end) begin
          emit = 1'b1; code = OUT_NO_FRAME;
        end else begin
          phase_nxt = PH_SEEK;
        end
      end else if (p_ge) begin
        emit = 1'b1; code = OUT_NO_FRAME;
      end else begin
        case (phase_c)
          PH_SEEK, PH_FILL: begin
            if (data_byte == MRK_FILL) begin
              phase_nxt = PH_FILL;
              if (p1_ge) begin
                emit = 1'b1; code = OUT_NO_FRAME;
              end
            end else if (phase_c == PH_FILL) begin
              if (data_byte == MRK_EOI || data_byte == MRK_SOS) begin
                emit = 1'b1; code = OUT_NO_FRAME;
              end else if (is_alone) begin
                if (top_end) begin
                  emit = 1'b1; code = OUT_NO_FRAME;
                end else begin
                  phase_nxt = PH_SEEK;
                end
              end else if (p2_ge) begin
                emit = 1'b1; code = OUT_NO_FRAME;
              end else begin
                marker_nxt = data_byte;
                phase_nxt  = PH_LENHI;
              end
            end else if (p1_ge) begin
              emit = 1'b1; code = OUT_NO_FRAME;
            end
          end
          PH_LENHI: begin
            seg_len_nxt = {data_byte, 8'h00};
            phase_nxt   = PH_LENLO;
          end
          PH_LENLO: begin
            seg_len_nxt = sl;
            if (sl < 16'd2 || seg_over) begin
              emit = 1'b1; code = OUT_NO_FRAME;
            end else if (is_sof && sl >= 16'd8) begin
              prog_nxt    = is_prog;
              seg_off_nxt = 16'd2;
              phase_nxt   = PH_FRAME;
            end else if (sl == 16'd2) begin
              if (top_end) begin
                emit = 1'b1; code = OUT_NO_FRAME;
              end else begin
                phase_nxt = PH_SEEK;
              end
            end else begin
              seg_off_nxt = 16'd2;
              phase_nxt   = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if ((17'(seg_off_c) + 17'd1) >= 17'(seg_len_c)) begin
              if (top_end) begin
                emit = 1'b1; code = OUT_NO_FRAME;
              end else begin
                phase_nxt = PH_SEEK;
              end
            end else begin
              seg_off_nxt = seg_off_c + 16'd1;
            end
          end
          PH_FRAME: begin
            seg_off_nxt = seg_off_c + 16'd1;
            case (seg_off_c)
              16'd3: height_nxt = {data_byte, 8'h00};
              16'd4: height_nxt = height_c | DIM_W'(data_byte);
              16'd5: width_nxt  = {data_byte, 8'h00};
              16'd6: width_nxt  = width_c | DIM_W'(data_byte);
              16'd7: begin
                if (data_byte == 8'd0 || data_byte > 8'd3 || seg_len_c < comp_need) begin
                  emit = 1'b1; code = OUT_BAD_COMP;
                end else begin
                  comp_tot_nxt = data_byte[1:0];
                  comp_idx_nxt = 2'd0;
                end
              end
              // sampling byte of each component; at most three components,
              // so the offset never passes fifteen inside the header
              16'd9, 16'd12, 16'd15: begin
                if (data_byte[7:4] > hmax_c) begin
                  hmax_nxt = data_byte[7:4];
                end
                if ((data_byte & NIB_MASK) > 8'(vmax_c)) begin
                  vmax_nxt = data_byte[3:0];
                end
                if ((3'(comp_idx_c) + 3'd1) >= 3'(comp_tot_c)) begin
                  emit = 1'b1;
                  code = (width_c != '0 && height_c != '0) ? OUT_OK : OUT_ZERO_SIZE;
                end else begin
                  comp_idx_nxt = comp_idx_c + 2'd1;
                end
              end
              default: ;
            endcase
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
      if (emit) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SOI0;   pos_r <= '0;     seg_len_r <= '0; seg_off_r <= '0;
      marker_r <= '0;       height_r <= '0;  width_r <= '0;
      comp_tot_r <= '0;     comp_idx_r <= '0;
      hmax_r <= SAMP_W'(1); vmax_r <= SAMP_W'(1); prog_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;   pos_r <= pos_nxt;   seg_len_r <= seg_len_nxt;
      seg_off_r <= seg_off_nxt; marker_r <= marker_nxt;
      height_r <= height_nxt; width_r <= width_nxt;
      comp_tot_r <= comp_tot_nxt; comp_idx_r <= comp_idx_nxt;
      hmax_r <= hmax_nxt;     vmax_r <= vmax_nxt; prog_r <= prog_nxt;
    end
  end

  assign res_valid          = step_en & emit;
  assign res.frame_found    = (code == OUT_OK);
  assign res.outcome        = code;
  assign res.frame_width    = width_nxt;
  assign res.frame_height   = height_nxt;
  assign res.progressive    = prog_nxt;
  assign res.max_h_sampling = hmax_nxt;
  assign res.max_v_sampling = vmax_nxt;

endmodule

@@ test/jpeg_frame_header_scanner_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpeg_frame_header_scanner_tb: self-checking bench for the frame header scanner
// streams short JPEG-like files byte by byte under a range of file lengths,
// predicts the one result per file and checks every field of every result beat
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner_tb;
  import jfhs_pkg::*;

  localparam int unsigned IMG_BYTES_MAX = 2097152;
  localparam int unsigned RUN_LIMIT     = 200000;  // cycles before the run is declared hung
  localparam int unsigned SETTLE_CYCLES = 4;       // result lands in the cycle after its beat
  localparam int unsigned RANDOM_BEATS  = 1420;

  // marker bytes the package does not name
  localparam logic [7:0] MRK_APP0 = 8'hE0;
  localparam logic [7:0] MRK_DQT  = 8'hDB;
  localparam logic [7:0] MRK_COM  = 8'hFE;
  localparam logic [7:0] PLAIN_MARKERS [5] = '{MRK_DHT, MRK_JPG, MRK_DAC, MRK_DQT, MRK_COM};

  typedef enum logic [3:0] {
    SCAN_SOI0, SCAN_SOI1, SCAN_SEEK, SCAN_FILL, SCAN_LENHI,
    SCAN_LENLO, SCAN_SKIP, SCAN_FRAME, SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } byte_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;    // [7:0] data_byte
  logic in_tuser = 1'b0;        // first_byte
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] out_tdata;  // see the port list of the block for the layout

  jpeg_frame_header_scanner #(
    .MAX_IMAGE_BYTES(IMG_BYTES_MAX)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bytes waiting to go out, the file under construction and the headers still owed
  byte_beat_t feed_q[$];
  logic [7:0] file_bytes[$];
  result_t    header_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // predictor: parser state mirrored beat by beat
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] scan_len = '0;  // copy of the length register
  scan_phase_t      scan_ph;
  logic [LEN_W-1:0] scan_pos;
  logic [15:0]      scan_seg_len;
  logic [15:0]      scan_off;
  logic [7:0]       scan_marker;
  logic [15:0]      scan_h;
  logic [15:0]      scan_w;
  logic [1:0]       scan_comp_total;
  logic [1:0]       scan_comp_idx;
  logic [3:0]       scan_hmax;
  logic [3:0]       scan_vmax;
  logic             scan_prog;

  // everything but the length register goes back to the start of a file
  function automatic void scan_clear();
    scan_ph         = SCAN_SOI0;
    scan_pos        = '0;
    scan_seg_len    = '0;
    scan_off        = '0;
    scan_marker     = '0;
    scan_h          = '0;
    scan_w          = '0;
    scan_comp_total = '0;
    scan_comp_idx   = '0;
    scan_hmax       = 4'd1;
    scan_vmax       = 4'd1;
    scan_prog       = 1'b0;
  endfunction

  function automatic void scan_report(input logic [CODE_W-1:0] code);
    result_t r;
    r.frame_found    = (code == OUT_OK);
    r.outcome        = code;
    r.frame_width    = scan_w;
    r.frame_height   = scan_h;
    r.progressive    = scan_prog;
    r.max_h_sampling = scan_hmax;
    r.max_v_sampling = scan_vmax;
    header_q.push_back(r);
    scan_ph = SCAN_DONE;
  endfunction

  // back to the marker hunt, unless no room is left for another marker
  function automatic void scan_resume(input int unsigned next, input int unsigned lim);
    if (next + 3 >= lim) scan_report(OUT_NO_FRAME);
    else scan_ph = SCAN_SEEK;
  endfunction

  task automatic scan_byte(input logic [7:0] b, input logic first);
    int unsigned p;
    int unsigned lim;
    int unsigned o;
    if (first) scan_clear();
    if (scan_ph == SCAN_DONE) return;
    p   = scan_pos;
    lim = (scan_len > IMG_BYTES_MAX) ? IMG_BYTES_MAX : scan_len;
    if (scan_pos != POS_MAX) scan_pos = scan_pos + 1'b1;

    if (scan_ph == SCAN_SOI0) begin
      if (lim < 4 || b != MRK_FILL) scan_report(OUT_NO_SOI);
      else scan_ph = SCAN_SOI1;
    end else if (scan_ph == SCAN_SOI1) begin
      if (lim < 4 || p >= lim || b != MRK_SOI) scan_report(OUT_NO_SOI);
      else scan_resume(p + 1, lim);
    end else if (p >= lim) begin
      scan_report(OUT_NO_FRAME);
    end else begin
      case (scan_ph)
        SCAN_SEEK, SCAN_FILL: begin
          if (b == MRK_FILL) begin
            scan_ph = SCAN_FILL;
            if (p + 1 >= lim) scan_report(OUT_NO_FRAME);
          end else if (scan_ph == SCAN_FILL) begin
            if (b == MRK_EOI || b == MRK_SOS) begin
              scan_report(OUT_NO_FRAME);
            end else if (b == MRK_TEM || (b >= MRK_RST0 && b <= MRK_RST7)) begin
              scan_resume(p + 1, lim);
            end else if (p + 2 >= lim) begin
              scan_report(OUT_NO_FRAME);
            end else begin
              scan_marker = b;
              scan_ph     = SCAN_LENHI;
            end
          end else if (p + 1 >= lim) begin
            scan_report(OUT_NO_FRAME);
          end
        end
        SCAN_LENHI: begin
          scan_seg_len = {b, 8'h00};
          scan_ph      = SCAN_LENLO;
        end
        SCAN_LENLO: begin
          scan_seg_len[7:0] = b;
          if (scan_seg_len < 2 || (p - 1) + scan_seg_len > lim) begin
            scan_report(OUT_NO_FRAME);
          end else if (scan_marker[7:4] == MRK_SOF0[7:4] && scan_marker != MRK_DHT &&
                       scan_marker != MRK_JPG && scan_marker != MRK_DAC &&
                       scan_seg_len >= 8) begin
            scan_prog = (scan_marker == MRK_SOF2 || scan_marker == MRK_SOF6 ||
                         scan_marker == MRK_SOFA || scan_marker == MRK_SOFE);
            scan_off  = 16'd2;
            scan_ph   = SCAN_FRAME;
          end else if (scan_seg_len == 2) begin
            scan_resume(p + 1, lim);
          end else begin
            scan_off = 16'd2;
            scan_ph  = SCAN_SKIP;
          end
        end
        SCAN_SKIP: begin
          if (scan_off + 1 >= scan_seg_len) scan_resume(p + 1, lim);
          else scan_off = scan_off + 1'b1;
        end
        SCAN_FRAME: begin
          o = scan_off;
          if (o == 3) begin
            scan_h = {b, 8'h00};
          end else if (o == 4) begin
            scan_h[7:0] = b;
          end else if (o == 5) begin
            scan_w = {b, 8'h00};
          end else if (o == 6) begin
            scan_w[7:0] = b;
          end else if (o == 7) begin
            // component count must be 1..3 and fit the segment
            if (b == 0 || b > 3 || scan_seg_len < 8 + 3 * b) begin
              scan_report(OUT_BAD_COMP);
              return;
            end
            scan_comp_total = b[1:0];
            scan_comp_idx   = '0;
          end else if (o >= 8 && (o - 8) % 3 == 1) begin
            // sampling byte: horizontal in the high nibble
            if (b[7:4] > scan_hmax) scan_hmax = b[7:4];
            if (b[3:0] > scan_vmax) scan_vmax = b[3:0];
            if (scan_comp_idx + 1 >= scan_comp_total) begin
              scan_report((scan_w != 0 && scan_h != 0) ? OUT_OK : OUT_ZERO_SIZE);
              return;
            end
            scan_comp_idx = scan_comp_idx + 1'b1;
          end
          scan_off = scan_off + 1'b1;
        end
        default: scan_ph = SCAN_DONE;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: one beat in flight, refilled from feed_q, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    byte_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      scan_clear();
    end else begin
      // the beat on the bus is taken at this edge
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (feed_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = feed_q.pop_front();
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.first;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: each result beat against the oldest expected header
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.frame_found    = out_tdata[0];
        got.outcome        = out_tdata[3:1];
        got.frame_width    = out_tdata[19:4];
        got.frame_height   = out_tdata[35:20];
        got.progressive    = out_tdata[36];
        got.max_h_sampling = out_tdata[40:37];
        got.max_v_sampling = out_tdata[44:41];
        if (header_q.size() == 0) begin
          $display("%0t ns: result expected none got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = header_q.pop_front();
          check_field("frame_found", want.frame_found, got.frame_found);
          check_field("outcome", want.outcome, got.outcome);
          check_field("frame_width", want.frame_width, got.frame_width);
          check_field("frame_height", want.frame_height, got.frame_height);
          check_field("progressive", want.progressive, got.progressive);
          check_field("max_h_sampling", want.max_h_sampling, got.max_h_sampling);
          check_field("max_v_sampling", want.max_v_sampling, got.max_v_sampling);
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL jpeg_frame_header_scanner");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all called on the falling edge
  // ---------------------------------------------------------------------------

  // hand the built file to the driver; only its first byte may carry first_byte
  task automatic send_file(input bit mark_first);
    byte_beat_t beat;
    foreach (file_bytes[i]) begin
      beat.data  = file_bytes[i];
      beat.first = mark_first && (i == 0);
      feed_q.push_back(beat);
    end
    beats_queued += file_bytes.size();
    file_bytes.delete();
  endtask

  // wait until every byte is gone and every header is back, then let the block drain
  task automatic settle();
    while (feed_q.size() != 0 || in_tvalid || header_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // length register write, only while nothing is in flight
  task automatic write_len(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    scan_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // one random file: mostly a start mark, a few segments and a frame header
  task automatic queue_file();
    int unsigned seg_len;
    int unsigned comp_cnt;
    int unsigned body;
    logic [7:0]  m;
    logic [15:0] h;
    logic [15:0] w;
    file_bytes.delete();
    if ($urandom_range(99, 0) < 8) begin
      // plain noise
      repeat ($urandom_range(12, 1)) file_bytes.push_back(8'($urandom));
    end else begin
      file_bytes.push_back(MRK_FILL);
      file_bytes.push_back(MRK_SOI);
      if ($urandom_range(19, 0) == 0) file_bytes[$urandom_range(1, 0)] = 8'($urandom);

      repeat ($urandom_range(4, 0)) begin
        case ($urandom_range(5, 0))
          0: begin
            // fill bytes then a marker with no length
            repeat ($urandom_range(3, 1)) file_bytes.push_back(MRK_FILL);
            if ($urandom_range(1, 0) != 0) file_bytes.push_back(MRK_TEM);
            else file_bytes.push_back(MRK_RST0 + 8'($urandom_range(7, 0)));
          end
          1: file_bytes.push_back(8'($urandom_range(254, 0)));  // stray byte between segments
          default: begin
            case ($urandom_range(3, 0))
              0: m = MRK_APP0 | 8'($urandom_range(15, 0));
              1: m = PLAIN_MARKERS[$urandom_range(4, 0)];
              2: m = 8'($urandom);
              default: m = MRK_SOF0 | 8'($urandom_range(15, 0));  // frame marker, short segment
            endcase
            seg_len = $urandom_range(7, 2);
            if ($urandom_range(14, 0) == 0) begin
              // broken length: too small or far past the file
              seg_len = ($urandom_range(1, 0) != 0) ? $urandom_range(1, 0)
                                                    : $urandom_range(65535, 0);
            end
            file_bytes.push_back(MRK_FILL);
            file_bytes.push_back(m);
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            body = (seg_len > 12) ? 10 : ((seg_len < 2) ? 0 : seg_len - 2);
            repeat (body) file_bytes.push_back(8'($urandom));
          end
        endcase
      end

      case ($urandom_range(9, 0))
        0: begin
          // scan or end marker before any frame header
          file_bytes.push_back(MRK_FILL);
          file_bytes.push_back(($urandom_range(1, 0) != 0) ? MRK_EOI : MRK_SOS);
        end
        1: ;  // file just stops
        default: begin
          do m = MRK_SOF0 | 8'($urandom_range(15, 0));
          while (m == MRK_DHT || m == MRK_JPG || m == MRK_DAC);
          comp_cnt = ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0)
                                                 : $urandom_range(3, 1);
          seg_len = 8 + 3 * comp_cnt;
          case ($urandom_range(9, 0))
            0: seg_len = $urandom_range(seg_len - 1, 7);  // too short for its components
            1: seg_len = seg_len + $urandom_range(3, 1);
            default: ;
          endcase
          h = ($urandom_range(7, 0) == 0) ? 16'd0 : 16'($urandom);
          w = ($urandom_range(7, 0) == 0) ? 16'd0 : 16'($urandom);
          file_bytes.push_back(MRK_FILL);
          file_bytes.push_back(m);
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          body = (seg_len > 40) ? 40 : seg_len;
          // segment offsets 2 up: precision, height, width, count, components
          for (int unsigned o = 2; o < body; o++) begin
            case (o)
              3: file_bytes.push_back(h[15:8]);
              4: file_bytes.push_back(h[7:0]);
              5: file_bytes.push_back(w[15:8]);
              6: file_bytes.push_back(w[7:0]);
              7: file_bytes.push_back(comp_cnt[7:0]);
              default: file_bytes.push_back(8'($urandom));
            endcase
          end
        end
      endcase
      // tail bytes, normally swallowed after the result
      repeat ($urandom_range(3, 0)) file_bytes.push_back(8'($urandom));
    end
    send_file($urandom_range(39, 0) != 0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned phase_no;
    logic [LEN_W-1:0] len;
    // 25 % sender gaps, 78 % receiver stalls to begin with
    send_idle_pct  = 25;
    recv_stall_pct = 78;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // length still zero from reset; a byte without first_byte opens the file
    file_bytes = '{8'h00};
    send_file(1'b0);
    settle();

    // file too short to hold a start mark
    write_len(LEN_W'(3));
    file_bytes = '{MRK_FILL};
    send_file(1'b1);
    settle();

    // fill bytes, standalone markers, a short frame segment that gets skipped,
    // then a progressive frame with zero height; the last byte is ignored
    write_len(LEN_W'(IMG_BYTES_MAX));
    file_bytes = '{MRK_FILL, MRK_SOI, MRK_FILL, MRK_FILL, MRK_RST0, MRK_FILL, MRK_TEM,
                   MRK_FILL, MRK_SOF0, 8'h00, 8'h04, 8'h00, 8'h00,
                   MRK_FILL, MRK_SOF2, 8'h00, 8'h0B, 8'h08, 8'h00, 8'h00, 8'h00, 8'h05,
                   8'h01, 8'h01, 8'hFF, 8'h00};
    send_file(1'b1);
    settle();

    // length cut below the current position halfway through a segment header
    file_bytes = '{MRK_FILL, MRK_SOI, MRK_FILL, MRK_APP0, 8'h00};
    send_file(1'b1);
    settle();
    write_len(LEN_W'(4));
    file_bytes = '{8'h10};
    send_file(1'b0);
    settle();

    // random files, one length per phase; every fourth phase an extreme length
    beats_queued = 0;
    phase_no = 0;
    while (beats_queued < RANDOM_BEATS) begin
      if (beats_queued < RANDOM_BEATS / 3) begin
        send_idle_pct  = 25;
        recv_stall_pct = 78;
      end else if (beats_queued < 2 * RANDOM_BEATS / 3) begin
        send_idle_pct  = 78;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (phase_no % 4 == 3) begin
        case ((phase_no / 4) % 5)
          0: len = '0;
          1: len = LEN_W'(IMG_BYTES_MAX);
          2: len = LEN_W'(1);
          3: len = LEN_W'(4);
          default: len = LEN_W'(IMG_BYTES_MAX - 1);
        endcase
      end else begin
        len = LEN_W'($urandom_range(90, 12));
      end
      settle();
      write_len(len);
      repeat ((len < 4) ? 3 : 6) queue_file();
      phase_no++;
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS jpeg_frame_header_scanner");
    end else begin
      $display("FAIL jpeg_frame_header_scanner");
    end
    $finish;
  end

endmodule
